// ===== rtl/core/assert_macros.svh =====
// Concurrent assertion helpers, sampled on clk and quiet while rst_n is low.
// The enclosing module must have signals named clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every sampled edge.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, prop, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/core/ile_pkg.sv =====
package ile_pkg;

  localparam int LIST_DEPTH_DEF  = 64;
  localparam int VALUE_WIDTH_DEF = 32;

  // fixed port widths
  localparam int DATA_W  = 32;
  localparam int INDEX_W = 7;
  localparam int COUNT_W = 7;

  typedef enum logic [1:0] {
    MODE_APPEND = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_GET    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_INDEX = 2'd1,
    ERR_FULL  = 2'd2
  } err_t;

  // per-cycle command broadcast to every cell; already qualified by
  // acceptance and by a clean error check
  typedef struct packed {
    logic ins;
    logic app;
    logic rem;
  } cell_ctl_t;

endpackage

// ===== rtl/core/indexed_list_engine.sv =====
// Channel | Direction | Ports                               | Handshake
// in      | input     | in_mode, in_value, in_index         | in_valid / in_stall
// out     | output    | out_data, out_count, out_error      | out_valid / out_stall
//
// One word is taken per cycle while in_stall is low; its result appears in the
// output register on the next cycle. Every entry lives in its own cell, so
// insert and remove shift every entry from the index upward in the cycle the
// word is taken. Reset clears the entry count and the output valid; the cell
// contents are left as they are. in_stall is high only while a result sits in
// the output register and the consumer stalls it.
`include "assert_macros.svh"

module indexed_list_engine
  import ile_pkg::*;
#(
  parameter int LIST_DEPTH  = LIST_DEPTH_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,

  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_mode,
  input  logic signed [DATA_W-1:0]  in_value,
  input  logic [INDEX_W-1:0]        in_index,

  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [DATA_W-1:0]  out_data,
  output logic [COUNT_W-1:0]        out_count,
  output logic [1:0]                out_error
);

  // count must reach LIST_DEPTH itself
  localparam int CW    = $clog2(LIST_DEPTH + 1);
  // common width for index/count compares
  localparam int CMP_W = (CW > INDEX_W) ? CW : INDEX_W;
  localparam int XW    = DATA_W + VALUE_WIDTH;
  localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(LIST_DEPTH);

  // ---------------------------------------------------------------- control
  logic                  accept;
  mode_t                 mode;
  logic [CMP_W-1:0]      idx_ext;
  logic [CMP_W-1:0]      cnt_ext;
  err_t                  err;
  cell_ctl_t             ctl;

  logic [CW-1:0]         count_r;
  logic [CW-1:0]         count_nxt;

  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic [DATA_W-1:0]     out_data_r;
  logic [COUNT_W-1:0]    out_count_r;
  err_t                  out_error_r;

  // ------------------------------------------------------------- data path
  logic [XW-1:0]          val_ext;
  logic [VALUE_WIDTH-1:0] wr_value;
  logic [VALUE_WIDTH-1:0] cell_q  [LIST_DEPTH];
  logic [VALUE_WIDTH-1:0] cell_rd [LIST_DEPTH];
  logic [VALUE_WIDTH-1:0] rd_sel;
  logic [XW-1:0]          rd_ext;
  logic [DATA_W-1:0]      data_res;
  logic [COUNT_W-1:0]     count_res;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign mode    = mode_t'(in_mode);
  assign idx_ext = CMP_W'(in_index);
  assign cnt_ext = CMP_W'(count_r);

  // sign-extend the port value into the store width (or cut it down)
  assign val_ext  = {{VALUE_WIDTH{in_value[DATA_W-1]}}, in_value};
  assign wr_value = val_ext[VALUE_WIDTH-1:0];

  // error check; on insert the index check wins over the full check
  always_comb begin
    err = ERR_OK;
    unique case (mode)
      MODE_APPEND: begin
        if (cnt_ext >= DEPTH_C) err = ERR_FULL;
      end
      MODE_INSERT: begin
        priority if (idx_ext > cnt_ext) err = ERR_INDEX;
        else if (cnt_ext >= DEPTH_C)    err = ERR_FULL;
        else                            err = ERR_OK;
      end
      MODE_REMOVE, MODE_GET: begin
        if (idx_ext >= cnt_ext) err = ERR_INDEX;
      end
    endcase
  end

  always_comb begin
    ctl.ins   = accept && (err == ERR_OK) && (mode == MODE_INSERT);
    ctl.app   = accept && (err == ERR_OK) && (mode == MODE_APPEND);
    ctl.rem   = accept && (err == ERR_OK) && (mode == MODE_REMOVE);
    count_nxt = count_r;
    if (ctl.ins || ctl.app) count_nxt = count_r + CW'(1);
    else if (ctl.rem)       count_nxt = count_r - CW'(1);
  end

  // ------------------------------------------------------------ cell chain
  genvar g;
  generate
    for (g = 0; g < LIST_DEPTH; g++) begin : g_cell
      ile_cell #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .CMP_W       (CMP_W),
        .POS         (g)
      ) u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .idx       (idx_ext),
        .cnt       (cnt_ext),
        .wr_value  (wr_value),
        // cell 0 never takes from below; top cell keeps itself on remove
        .prev_data ((g == 0) ? wr_value : cell_q[(g == 0) ? 0 : g - 1]),
        .next_data ((g == LIST_DEPTH - 1) ? cell_q[g]
                                          : cell_q[(g == LIST_DEPTH - 1) ? g : g + 1]),
        .data_o    (cell_q[g]),
        .rd_o      (cell_rd[g])
      );
    end
  endgenerate

  // at most one cell matches the index, the rest drive zero
  always_comb begin
    rd_sel = '0;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      rd_sel = rd_sel | cell_rd[i];
    end
  end

  // store word to port width: zero-fill if narrower, low bits if wider
  assign rd_ext   = XW'(rd_sel);
  assign data_res = ((err == ERR_OK) && ((mode == MODE_REMOVE) || (mode == MODE_GET)))
                    ? rd_ext[DATA_W-1:0] : '0;

  generate
    if (CW >= COUNT_W) begin : g_cnt_cut
      assign count_res = count_nxt[COUNT_W-1:0];
    end else begin : g_cnt_ext
      assign count_res = COUNT_W'(count_nxt);
    end
  endgenerate

  // --------------------------------------------------------- output stage
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept)          out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r  <= data_res;
      out_count_r <= count_res;
      out_error_r <= err;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_count = out_count_r;
  assign out_error = out_error_r;

  // ------------------------------------------------------------ assertions
  `ASSERT_ALWAYS(a_count_bound, count_r <= CW'(LIST_DEPTH), "entry count above depth")
  `ASSERT_NEXT(a_accept_loads, accept, out_valid_r, "accepted word produced no result")
  `ASSERT_NEXT(a_err_holds_count, accept && (err != ERR_OK), count_r == $past(count_r), "failed request changed the count")
  `ASSERT_ALWAYS(a_out_count_track, !out_valid_r || (out_count_r == count_res) || accept, "shown count differs from stored count")

endmodule

// ===== rtl/core/ile_cell.sv =====
module ile_cell
  import ile_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int CMP_W       = COUNT_W,
  parameter int POS         = 0
) (
  input  logic                   clk,
  input  cell_ctl_t              ctl,
  input  logic [CMP_W-1:0]       idx,
  input  logic [CMP_W-1:0]       cnt,
  input  logic [VALUE_WIDTH-1:0] wr_value,
  input  logic [VALUE_WIDTH-1:0] prev_data,
  input  logic [VALUE_WIDTH-1:0] next_data,
  output logic [VALUE_WIDTH-1:0] data_o,
  output logic [VALUE_WIDTH-1:0] rd_o
);

  localparam logic [CMP_W-1:0] POS_C = CMP_W'(POS);

  logic [VALUE_WIDTH-1:0] data_r;
  logic [VALUE_WIDTH-1:0] data_nxt;
  logic                   hit;

  assign hit = (idx == POS_C);

  always_comb begin
    priority if (ctl.ins && hit) begin
      data_nxt = wr_value;
    end else if (ctl.ins && (POS_C > idx)) begin
      data_nxt = prev_data;          // shift up from lower neighbor
    end else if (ctl.app && (cnt == POS_C)) begin
      data_nxt = wr_value;
    end else if (ctl.rem && (POS_C >= idx)) begin
      data_nxt = next_data;          // shift down from upper neighbor
    end else begin
      data_nxt = data_r;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;
  assign rd_o   = hit ? data_r : '0;

endmodule

// ===== dv/list_checker.sv =====
`timescale 1ns / 1ps

module list_checker
  import ile_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic [1:0]               in_mode,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic [INDEX_W-1:0]       in_index,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic signed [DATA_W-1:0] out_data,
  input  logic [COUNT_W-1:0]       out_count,
  input  logic [1:0]               out_error,
  output int                       fail_count,
  output int                       pending
);

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic [COUNT_W-1:0]       count;
    err_t                     error;
  } list_result_t;

  logic signed [DATA_W-1:0] shadow_list [LIST_DEPTH_DEF];
  int                       shadow_count;
  list_result_t             expected_results [$];

  // applies one list operation to the shadow copy, returns the result word
  function automatic list_result_t apply_list_op(mode_t mode,
                                                 logic signed [DATA_W-1:0] value,
                                                 int idx);
    list_result_t r;
    int i;
    r.data  = '0;
    r.error = ERR_OK;
    case (mode)
      MODE_APPEND: begin
        if (shadow_count >= LIST_DEPTH_DEF) begin
          r.error = ERR_FULL;
        end else begin
          shadow_list[shadow_count] = value;
          shadow_count++;
        end
      end
      MODE_INSERT: begin
        // index check wins over the full check
        if (idx > shadow_count) begin
          r.error = ERR_INDEX;
        end else if (shadow_count >= LIST_DEPTH_DEF) begin
          r.error = ERR_FULL;
        end else begin
          for (i = shadow_count; i > idx; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[idx] = value;
          shadow_count++;
        end
      end
      default: begin
        if (idx >= shadow_count) begin
          r.error = ERR_INDEX;
        end else begin
          r.data = shadow_list[idx];
          if (mode == MODE_REMOVE) begin
            for (i = idx; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
            shadow_count--;
          end
        end
      end
    endcase
    r.count = shadow_count[COUNT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    list_result_t want;
    if (!rst_n) begin
      shadow_count = 0;
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result word with nothing expected: data %0d count %0d error %0d",
                 out_data, out_count, out_error);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_data !== want.data) begin
            $error("data mismatch: expected %0d, actual %0d", want.data, out_data);
            fail_count++;
          end
          if (out_count !== want.count) begin
            $error("count mismatch: expected %0d, actual %0d", want.count, out_count);
            fail_count++;
          end
          if (out_error !== want.error) begin
            $error("error mismatch: expected %0d, actual %0d", want.error, out_error);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall)
        expected_results.push_back(apply_list_op(mode_t'(in_mode), in_value, int'(in_index)));
    end
    pending <= expected_results.size();
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import ile_pkg::*;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [1:0]               in_mode;
  logic signed [DATA_W-1:0] in_value;
  logic [INDEX_W-1:0]       in_index;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [DATA_W-1:0] out_data;
  logic [COUNT_W-1:0]       out_count;
  logic [1:0]               out_error;

  int fail_count;
  int pending;

  // stimulus-side view of the list length, just enough to aim indexes
  int list_len;
  // no idling on either side while set
  bit quiet_phase;
  // asks the receiver for one long hold-off
  bit hold_off_req;

  // 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  indexed_list_engine u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_mode   (in_mode),
    .in_value  (in_value),
    .in_index  (in_index),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .out_count (out_count),
    .out_error (out_error)
  );

  list_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_mode    (in_mode),
    .in_value   (in_value),
    .in_index   (in_index),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .out_count  (out_count),
    .out_error  (out_error),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Offer one word after a random gap and hold it until accepted. With a zero
  // gap valid simply stays high from the previous word, so it is never
  // dropped and raised in the same step.
  task automatic send_word(input mode_t mode, input logic signed [DATA_W-1:0] value,
                           input int idx);
    int gap;
    gap = quiet_phase ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode  <= mode;
    in_value <= value;
    in_index <= idx[INDEX_W-1:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // track the length so later indexes land near the live range
    case (mode)
      MODE_APPEND: if (list_len < LIST_DEPTH_DEF) list_len++;
      MODE_INSERT: if (idx <= list_len && list_len < LIST_DEPTH_DEF) list_len++;
      MODE_REMOVE: if (idx < list_len) list_len--;
      default: ;
    endcase
  endtask

  // Stop offering and wait for every outstanding result. Waiting for a clock edge
  // first lets the checker's count take in the last accepted word.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
  endtask

  // One random word. grow_pct / shrink_pct bias the mix so the list sweeps
  // between empty and full; the rest are gets.
  task automatic random_word(input int grow_pct, input int shrink_pct);
    int roll;
    int idx;
    mode_t mode;
    logic signed [DATA_W-1:0] value;
    roll = $urandom_range(0, 99);
    if (roll < grow_pct)
      mode = $urandom_range(0, 1) ? MODE_APPEND : MODE_INSERT;
    else if (roll < grow_pct + shrink_pct)
      mode = MODE_REMOVE;
    else
      mode = MODE_GET;
    // mostly in range (count itself included), some just past the end,
    // some anywhere in the 7-bit field
    roll = $urandom_range(0, 9);
    if (roll < 8)
      idx = $urandom_range(0, list_len);
    else if (roll == 8)
      idx = list_len + $urandom_range(0, 2);
    else
      idx = $urandom_range(0, 127);
    roll = $urandom_range(0, 7);
    case (roll)
      0: value = 32'h7fff_ffff;
      1: value = 32'h8000_0000;
      2: value = '0;
      3: value = '1;
      default: value = $urandom();
    endcase
    send_word(mode, value, idx);
  endtask

  // Receiver: a random stall before each result word, or one long hold-off
  // on request so the output register fills and in_stall rises while the
  // sender keeps offering.
  initial begin
    int wait_cycles;
    forever begin
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        wait_cycles = quiet_phase ? 0 : $urandom_range(0, 15);
        if (wait_cycles > 0) begin
          out_stall <= 1'b1;
          repeat (wait_cycles) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Hard limit, far beyond the slowest legal run.
  initial begin
    #400000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int grow_pct;
    int shrink_pct;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_mode      <= MODE_APPEND;
    in_value     <= '0;
    in_index     <= '0;
    list_len     = 0;
    quiet_phase  = 1'b0;
    hold_off_req = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty-list errors, value extremes, insert before the last
    // entry, insert at the end, and reads/removes at and past the end
    send_word(MODE_GET,    '0,           0);   // get on empty
    send_word(MODE_REMOVE, '0,           0);   // remove on empty
    send_word(MODE_INSERT, 32'sd9,       1);   // insert past the end
    send_word(MODE_INSERT, 32'sd5,       0);   // insert at end of empty list
    send_word(MODE_APPEND, 32'h7fff_ffff, 0);
    send_word(MODE_APPEND, 32'h8000_0000, 0);
    send_word(MODE_INSERT, '1,           2);   // insert before the last entry
    send_word(MODE_INSERT, 32'h1234_5678, 4);  // index equal to count appends
    send_word(MODE_GET,    '0,           0);
    send_word(MODE_GET,    '0,           4);   // last entry
    send_word(MODE_GET,    '0,           5);   // index equal to count
    send_word(MODE_GET,    '0,           127);
    send_word(MODE_INSERT, 32'sd3,       127);
    send_word(MODE_REMOVE, '0,           4);   // remove the last entry
    send_word(MODE_REMOVE, '0,           0);   // remove the first entry
    send_word(MODE_REMOVE, '0,           3);   // index equal to count
    send_word(MODE_GET,    '0,           1);
    send_word(MODE_APPEND, 32'h5555_aaaa, 0);
    drain_results();

    // random phases: fill to full, mix, drain to empty, fill again, mix, drain and
    // mix once more; the sender pauses for all results at every phase boundary
    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0, 1, 5, 6: begin grow_pct = 80; shrink_pct = 10; end
        3, 4, 8:    begin grow_pct = 10; shrink_pct = 80; end
        default:    begin grow_pct = 45; shrink_pct = 35; end
      endcase
      quiet_phase = (phase == 4 || phase == 6);
      if (phase == 2) hold_off_req = 1'b1;
      repeat (100) random_word(grow_pct, shrink_pct);
      drain_results();
    end

    // tail: a few spare edges catch stray words
    repeat (4) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
